// ===== sv/tti_pkg.sv =====
// shared constants and types for the tensor transpose index map
// no dependencies; imported by tti_cfg, tti_dim and the top level
package tti_pkg;

    localparam int MAX_RANK_DEF   = 6;
    localparam int INDEX_BITS_DEF = 32;
    localparam int DIM_BITS_DEF   = 16;

    localparam int OUT_FIELD_BITS = 32;
    localparam int ADDR_BITS      = 5;
    localparam int ADDR_LSB       = 3;
    localparam int DATA_BITS      = 64;

    localparam int RANK_BITS = 3;
    localparam int PERM_BITS = 18;
    localparam int DIMS_BITS = 48;
    localparam int AXIS_BITS = 3;

    typedef logic [ADDR_BITS-ADDR_LSB-1:0] t_reg_idx;

    localparam t_reg_idx REG_RANK    = 2'd0;
    localparam t_reg_idx REG_PERM    = 2'd1;
    localparam t_reg_idx REG_DIMS_LO = 2'd2;
    localparam t_reg_idx REG_DIMS_HI = 2'd3;

    localparam logic [RANK_BITS-1:0] RANK_RST = 3'd1;
    localparam logic [PERM_BITS-1:0] PERM_RST = 18'd181896;
    localparam logic [DIMS_BITS-1:0] DIMS_RST = 48'h0001_0001_0001;

    // status of the geometry sequencer toward the datapath
    typedef struct packed {
        logic busy;
        logic numel_sat;
    } t_geom_ctl;

endpackage

// ===== sv/tti_cfg.sv =====
// register file and geometry sequencer: strides, element count and permuted strides
// depends on tti_pkg
module tti_cfg #(
    parameter int MAX_RANK   = tti_pkg::MAX_RANK_DEF,
    parameter int INDEX_BITS = tti_pkg::INDEX_BITS_DEF,
    parameter int DIM_BITS   = tti_pkg::DIM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tti_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [tti_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tti_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    output logic [INDEX_BITS-1:0]               o_stride [MAX_RANK],
    output logic [MAX_RANK-1:0]                 o_skip,
    output logic [INDEX_BITS-1:0]               o_sstr [MAX_RANK],
    output logic [INDEX_BITS-1:0]               o_numel,
    output tti_pkg::t_geom_ctl                  o_ctl
);
    import tti_pkg::*;

    localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int KW = $clog2(DIM_BITS);
    localparam int MW = 64 + DIM_BITS;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_NEXT, S_SEL} t_state;

    t_state                  r_state;
    logic [RANK_BITS-1:0]    r_rank;
    logic [PERM_BITS-1:0]    r_perm;
    logic [DIMS_BITS-1:0]    r_dims_lo;
    logic [DIMS_BITS-1:0]    r_dims_hi;
    logic [IW-1:0]           r_pos;
    logic [63:0]             r_po;
    logic                    r_pb;
    logic [INDEX_BITS-1:0]   r_pi;
    logic [MW-1:0]           r_mo;
    logic [MW-1:0]           r_ao;
    logic [INDEX_BITS-1:0]   r_mi;
    logic [INDEX_BITS-1:0]   r_ai;
    logic [DIM_BITS-1:0]     r_mq;
    logic [DIM_BITS-1:0]     r_mj;
    logic [KW-1:0]           r_k;
    logic [INDEX_BITS-1:0]   r_stride [MAX_RANK];
    logic [MAX_RANK-1:0]     r_skip;
    logic [INDEX_BITS-1:0]   r_istr [MAX_RANK];
    logic [INDEX_BITS-1:0]   r_sstr [MAX_RANK];
    logic [INDEX_BITS-1:0]   r_numel;
    logic                    r_nsat;

    logic                    wr;
    logic [3:0]              rc;
    logic [AXIS_BITS-1:0]    ax   [MAX_RANK];
    logic [DIM_BITS-1:0]     odim [MAX_RANK];
    logic [DIM_BITS-1:0]     idim [MAX_RANK];
    logic [63:0]             lo64;
    logic [63:0]             hi64;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign lo64   = 64'(r_dims_lo);
    assign hi64   = 64'(r_dims_hi);

    always_comb begin
        if (r_rank == '0) begin
            rc = 4'd1;
        end else if ({1'b0, r_rank} > 4'(MAX_RANK)) begin
            rc = 4'(MAX_RANK);
        end else begin
            rc = {1'b0, r_rank};
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RANK; i++) begin
            int sh;
            sh = (i % 3) * DIM_BITS;
            ax[i] = AXIS_BITS'(r_perm >> (3 * i));
            if (i >= 6) begin
                odim[i] = DIM_BITS'(1);
            end else if (sh >= 64) begin
                odim[i] = '0;
            end else begin
                odim[i] = DIM_BITS'(((i < 3) ? lo64 : hi64) >> sh);
            end
        end
        for (int j = 0; j < MAX_RANK; j++) begin
            idim[j] = DIM_BITS'(1);
        end
        // later positions win when an axis is named twice
        for (int i = 0; i < MAX_RANK; i++) begin
            if (4'(i) < rc && {1'b0, ax[i]} < rc) begin
                idim[ax[i][IW-1:0]] = odim[i];
            end
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[ADDR_BITS-1:ADDR_LSB]))
            REG_RANK:    prdata = DATA_BITS'(r_rank);
            REG_PERM:    prdata = DATA_BITS'(r_perm);
            REG_DIMS_LO: prdata = DATA_BITS'(r_dims_lo);
            REG_DIMS_HI: prdata = DATA_BITS'(r_dims_hi);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_rank    <= RANK_RST;
            r_perm    <= PERM_RST;
            r_dims_lo <= DIMS_RST;
            r_dims_hi <= DIMS_RST;
            r_pos     <= IW'(MAX_RANK - 1);
            r_po      <= 64'd1;
            r_pb      <= 1'b0;
            r_pi      <= INDEX_BITS'(1);
        end else if (wr) begin
            unique case (t_reg_idx'(paddr[ADDR_BITS-1:ADDR_LSB]))
                REG_RANK:    r_rank    <= pwdata[RANK_BITS-1:0];
                REG_PERM:    r_perm    <= pwdata[PERM_BITS-1:0];
                REG_DIMS_LO: r_dims_lo <= pwdata[DIMS_BITS-1:0];
                REG_DIMS_HI: r_dims_hi <= pwdata[DIMS_BITS-1:0];
            endcase
            // any write reruns the geometry from the innermost position
            r_state <= S_LOAD;
            r_pos   <= IW'(MAX_RANK - 1);
            r_po    <= 64'd1;
            r_pb    <= 1'b0;
            r_pi    <= INDEX_BITS'(1);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_LOAD: begin
                    if (4'(r_pos) < rc) begin
                        r_stride[r_pos] <= r_po[INDEX_BITS-1:0];
                        r_skip[r_pos]   <= r_pb || (r_po == '0) || ((r_po >> INDEX_BITS) != '0);
                        r_istr[r_pos]   <= r_pi;
                        r_mo            <= MW'(r_po);
                        r_mi            <= r_pi;
                        r_mq            <= odim[r_pos];
                        r_mj            <= idim[r_pos];
                        r_ao            <= '0;
                        r_ai            <= '0;
                        r_k             <= '0;
                        r_state         <= S_MUL;
                    end else begin
                        r_skip[r_pos] <= 1'b1;
                        r_istr[r_pos] <= '0;
                        if (r_pos == '0) begin
                            r_state <= S_SEL;
                        end else begin
                            r_pos <= r_pos - 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    // shift-add, one multiplier bit per cycle for both running products
                    if (r_mq[0]) begin
                        r_ao <= r_ao + r_mo;
                    end
                    if (r_mj[0]) begin
                        r_ai <= r_ai + r_mi;
                    end
                    r_mo <= r_mo << 1;
                    r_mi <= r_mi << 1;
                    r_mq <= r_mq >> 1;
                    r_mj <= r_mj >> 1;
                    r_k  <= r_k + 1'b1;
                    if (r_k == KW'(DIM_BITS - 1)) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_pb <= r_pb || ((r_ao >> 64) != '0);
                    r_po <= r_ao[63:0];
                    r_pi <= r_ai;
                    if (r_pos == '0) begin
                        r_state <= S_SEL;
                    end else begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_SEL: begin
                    for (int i = 0; i < MAX_RANK; i++) begin
                        r_sstr[i] <= ({1'b0, ax[i]} < 4'(MAX_RANK)) ?
                                     r_istr[ax[i][IW-1:0]] : '0;
                    end
                    r_numel <= r_po[INDEX_BITS-1:0];
                    r_nsat  <= r_pb || ((r_po >> INDEX_BITS) != '0);
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stride      = r_stride;
    assign o_skip        = r_skip;
    assign o_sstr        = r_sstr;
    assign o_numel       = r_numel;
    assign o_ctl.busy    = (r_state != S_IDLE);
    assign o_ctl.numel_sat = r_nsat;

endmodule

// ===== sv/tti_dim.sv =====
// one output dimension: pipelined restoring divide by the output stride,
// then multiply by the permuted input stride and accumulate; depends on tti_pkg
module tti_dim #(
    parameter int INDEX_BITS = tti_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [INDEX_BITS-1:0] i_rem,
    input  logic [INDEX_BITS-1:0] i_acc,
    input  logic                  i_oor,
    input  logic [INDEX_BITS-1:0] i_stride,
    input  logic                  i_skip,
    input  logic [INDEX_BITS-1:0] i_sstr,
    output logic                  o_vld,
    output logic [INDEX_BITS-1:0] o_rem,
    output logic [INDEX_BITS-1:0] o_acc,
    output logic                  o_oor
);
    import tti_pkg::*;

    // s_* is the input of divider stage j, r_* its registered output
    logic                  s_vld [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] s_rem [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] s_q   [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] s_acc [INDEX_BITS+1];
    logic                  s_oor [INDEX_BITS+1];

    logic                  r_vld [INDEX_BITS];
    logic [INDEX_BITS-1:0] r_rem [INDEX_BITS];
    logic [INDEX_BITS-1:0] r_q   [INDEX_BITS];
    logic [INDEX_BITS-1:0] r_acc [INDEX_BITS];
    logic                  r_oor [INDEX_BITS];

    logic                  r_mvld;
    logic [INDEX_BITS-1:0] r_mrem;
    logic [INDEX_BITS-1:0] r_mprod;
    logic [INDEX_BITS-1:0] r_macc;
    logic                  r_moor;
    logic                  r_avld;
    logic [INDEX_BITS-1:0] r_arem;
    logic [INDEX_BITS-1:0] r_aacc;
    logic                  r_aoor;

    assign s_vld[0] = i_vld;
    assign s_rem[0] = i_rem;
    assign s_q[0]   = '0;
    assign s_acc[0] = i_acc;
    assign s_oor[0] = i_oor;

    for (genvar j = 0; j < INDEX_BITS; j++) begin : g_step
        localparam int B = INDEX_BITS - 1 - j;
        logic ge;

        // quotient bit B: remainder still holds stride << B
        assign ge = !i_skip && ((s_rem[j] >> B) >= i_stride);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? (s_rem[j] - INDEX_BITS'(i_stride << B)) : s_rem[j];
                r_q[j]   <= s_q[j] | (INDEX_BITS'(ge) << B);
                r_acc[j] <= s_acc[j];
                r_oor[j] <= s_oor[j];
            end
        end

        assign s_vld[j+1] = r_vld[j];
        assign s_rem[j+1] = r_rem[j];
        assign s_q[j+1]   = r_q[j];
        assign s_acc[j+1] = r_acc[j];
        assign s_oor[j+1] = r_oor[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
            r_avld <= 1'b0;
        end else if (i_en) begin
            r_mvld <= s_vld[INDEX_BITS];
            r_avld <= r_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mrem  <= s_rem[INDEX_BITS];
            r_mprod <= INDEX_BITS'(s_q[INDEX_BITS] * i_sstr);
            r_macc  <= s_acc[INDEX_BITS];
            r_moor  <= s_oor[INDEX_BITS];
            r_arem  <= r_mrem;
            r_aacc  <= r_macc + r_mprod;
            r_aoor  <= r_moor;
        end
    end

    assign o_vld = r_avld;
    assign o_rem = r_arem;
    assign o_acc = r_aacc;
    assign o_oor = r_aoor;

endmodule

// ===== sv/tensor_transpose_index_map.sv =====
// Tensor transpose index map. Input channel i_valid/o_ready carries i_out_index,
// a row-major output index; output channel o_valid/i_ready returns o_in_index,
// the row-major source index, and o_out_of_range, set (with index 0) when the
// output index is not below the element count. One result per transaction,
// in order. Configuration goes through the APB port (registers at 8*i).
// Throughput: one transaction per cycle while o_ready is high. Each dimension
// is a restoring divider, one quotient bit per stage, followed by a multiply
// and an accumulate stage. After reset and after every register write a
// shift-add sequencer rebuilds the strides, and o_ready stays low until it
// is done. Register writes are taken at any time.
// When the receiver stalls, a skid register takes one more result; after
// that the whole pipeline holds and o_ready drops. Nothing is lost.
// depends on tti_pkg, tti_cfg, tti_dim
module tensor_transpose_index_map #(
    parameter int MAX_RANK   = tti_pkg::MAX_RANK_DEF,
    parameter int INDEX_BITS = tti_pkg::INDEX_BITS_DEF,
    parameter int DIM_BITS   = tti_pkg::DIM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tti_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tti_pkg::DATA_BITS-1:0] pwdata,
    output logic [tti_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [INDEX_BITS-1:0]         i_out_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [INDEX_BITS-1:0]         o_in_index,
    output logic                          o_out_of_range
);
    import tti_pkg::*;

    localparam int OW = (INDEX_BITS < OUT_FIELD_BITS) ? INDEX_BITS : OUT_FIELD_BITS;
    localparam logic [INDEX_BITS-1:0] ALL_ONES = '1;
    localparam logic [INDEX_BITS-1:0] OUT_MASK = ALL_ONES >> (INDEX_BITS - OW);

    logic [INDEX_BITS-1:0] stride [MAX_RANK];
    logic [MAX_RANK-1:0]   skip;
    logic [INDEX_BITS-1:0] sstr   [MAX_RANK];
    logic [INDEX_BITS-1:0] numel;
    t_geom_ctl             ctl;

    logic                  en;
    logic                  r_in_vld;
    logic [INDEX_BITS-1:0] r_in_idx;
    logic                  r_in_oor;

    logic                  d_vld [MAX_RANK+1];
    logic [INDEX_BITS-1:0] d_rem [MAX_RANK+1];
    logic [INDEX_BITS-1:0] d_acc [MAX_RANK+1];
    logic                  d_oor [MAX_RANK+1];

    logic [INDEX_BITS-1:0] res_idx;
    logic                  r_out_vld;
    logic [INDEX_BITS-1:0] r_out_idx;
    logic                  r_out_oor;
    logic                  r_skid_vld;
    logic [INDEX_BITS-1:0] r_skid_idx;
    logic                  r_skid_oor;

    tti_cfg #(
        .MAX_RANK   (MAX_RANK),
        .INDEX_BITS (INDEX_BITS),
        .DIM_BITS   (DIM_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_stride (stride),
        .o_skip   (skip),
        .o_sstr   (sstr),
        .o_numel  (numel),
        .o_ctl    (ctl)
    );

    // pipeline moves whenever the skid slot is free
    assign en      = !r_skid_vld;
    assign o_ready = en && !ctl.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid && !ctl.busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_idx <= i_out_index;
            r_in_oor <= !ctl.numel_sat && (i_out_index >= numel);
        end
    end

    assign d_vld[0] = r_in_vld;
    assign d_rem[0] = r_in_idx;
    assign d_acc[0] = '0;
    assign d_oor[0] = r_in_oor;

    for (genvar i = 0; i < MAX_RANK; i++) begin : g_dim
        tti_dim #(
            .INDEX_BITS (INDEX_BITS)
        ) u_dim (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_vld    (d_vld[i]),
            .i_rem    (d_rem[i]),
            .i_acc    (d_acc[i]),
            .i_oor    (d_oor[i]),
            .i_stride (stride[i]),
            .i_skip   (skip[i]),
            .i_sstr   (sstr[i]),
            .o_vld    (d_vld[i+1]),
            .o_rem    (d_rem[i+1]),
            .o_acc    (d_acc[i+1]),
            .o_oor    (d_oor[i+1])
        );
    end

    assign res_idx = d_oor[MAX_RANK] ? '0 : (d_acc[MAX_RANK] & OUT_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (i_ready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (d_vld[MAX_RANK]) begin
                if (r_out_vld && !i_ready) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out_idx <= r_skid_idx;
                r_out_oor <= r_skid_oor;
            end
        end else if (d_vld[MAX_RANK]) begin
            if (r_out_vld && !i_ready) begin
                r_skid_idx <= res_idx;
                r_skid_oor <= d_oor[MAX_RANK];
            end else begin
                r_out_idx <= res_idx;
                r_out_oor <= d_oor[MAX_RANK];
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_in_index     = r_out_idx;
    assign o_out_of_range = r_out_oor;

endmodule

// ===== sim/tb.sv =====
// testbench for tensor_transpose_index_map: random and directed output indexes
// checked against a behavioral transpose index predictor; depends on tti_pkg
`timescale 1ns / 100ps

module tb;
    import tti_pkg::*;

    localparam int RANK_MAX = 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [31:0]          i_out_index = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [31:0]          o_in_index;
    logic                 o_out_of_range;

    typedef struct packed {
        logic [31:0] in_index;
        logic        oor;
    } t_src_addr;

    t_src_addr   src_addr_q[$];
    int          n_mismatch = 0;
    int          n_results = 0;
    int          n_oor = 0;
    int          n_taken = 0;
    int          hold_cycles = 0;
    int          sink_wait = 0;
    int          sink_seen = 0;
    bit          rand_sink = 1'b0;

    logic [RANK_BITS-1:0] m_rank;
    logic [PERM_BITS-1:0] m_perm;
    logic [DIMS_BITS-1:0] m_dims_lo, m_dims_hi;

    tensor_transpose_index_map dut (.*);

    always #5 i_clk = ~i_clk;

    // expected source address for one output index
    function automatic t_src_addr map_index(logic [31:0] idx);
        logic [63:0] odim[8], idim[8], ostr[8], istr[8];
        bit          obig[8];
        int unsigned ax[8];
        int          r;
        logic [63:0] prod, tmp, numel, c, acc;
        logic [127:0] wide;
        bit          big, nbig;
        t_src_addr   res;
        r = m_rank;
        if (r < 1) r = 1;
        if (r > RANK_MAX) r = RANK_MAX;
        for (int i = 0; i < 8; i++) begin
            if (i < 3) odim[i] = 64'(m_dims_lo[16*i +: 16]);
            else if (i < 6) odim[i] = 64'(m_dims_hi[16*(i-3) +: 16]);
            else odim[i] = 64'd1;
            idim[i] = 64'd1;
            ax[i] = (i < 6) ? m_perm[3*i +: 3] : 0;
        end
        for (int i = 0; i < r; i++)
            if (ax[i] < r) idim[ax[i]] = odim[i];
        prod = 64'd1;
        big = 1'b0;
        for (int i = r - 1; i >= 0; i--) begin
            ostr[i] = prod;
            obig[i] = big;
            wide = 128'(prod) * 128'(odim[i]);
            if (wide[127:64] != 0) begin
                big = 1'b1;
                prod = '1;
            end else prod = wide[63:0];
        end
        numel = prod;
        nbig = big;
        prod = 64'd1;
        for (int i = 7; i >= 0; i--) begin
            if (i >= r) istr[i] = '0;
            else begin
                istr[i] = prod;
                prod = prod * idim[i];
            end
        end
        if (!nbig && 64'(idx) >= numel) begin
            res.in_index = '0;
            res.oor = 1'b1;
            return res;
        end
        acc = '0;
        tmp = 64'(idx);
        for (int i = 0; i < r; i++) begin
            c = '0;
            if (!obig[i] && ostr[i] != 0) begin
                c = tmp / ostr[i];
                tmp = tmp - c * ostr[i];
            end
            acc = acc + c * istr[ax[i] & 7];
        end
        res.in_index = acc[31:0];
        res.oor = 1'b0;
        return res;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_RANK:    m_rank = val[RANK_BITS-1:0];
            REG_PERM:    m_perm = val[PERM_BITS-1:0];
            REG_DIMS_LO: m_dims_lo = val[DIMS_BITS-1:0];
            default:     m_dims_hi = val[DIMS_BITS-1:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (src_addr_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_shape(int r, logic [17:0] perm, logic [47:0] lo, logic [47:0] hi);
        drain();
        reg_write(REG_RANK, 64'(r));
        reg_write(REG_PERM, 64'(perm));
        reg_write(REG_DIMS_LO, 64'(lo));
        reg_write(REG_DIMS_HI, 64'(hi));
    endtask

    // one transaction on the input channel, with optional random gap;
    // returns at the accepting edge with valid still high
    task automatic send_index(logic [31:0] idx, bit gap = 1'b1);
        int wait_n;
        wait_n = gap ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        @(negedge i_clk);
        if (wait_n > 0) begin
            i_valid <= 1'b0;
            repeat (wait_n) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_out_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        src_addr_q.push_back(map_index(idx));
    endtask

    // result side: random wait per transaction, optional long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else if (!rand_sink) i_ready <= 1'b1;
        else begin
            if (n_taken != sink_seen) begin
                sink_seen = n_taken;
                sink_wait = $urandom_range(0, 8);
            end
            if (sink_wait > 0) begin
                sink_wait = sink_wait - 1;
                i_ready <= 1'b0;
            end else i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_src_addr want;
            n_taken++;
            if (src_addr_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected transaction: %h", o_in_index);
            end else begin
                want = src_addr_q.pop_front();
                n_results++;
                if (want.oor) n_oor++;
                if (o_in_index !== want.in_index || o_out_of_range !== want.oor) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected idx %h oor %b, got idx %h oor %b",
                                 want.in_index, want.oor, o_in_index, o_out_of_range);
                end
            end
        end
    end

    function automatic logic [47:0] rand_dims(int maxd);
        return {16'($urandom_range(1, maxd)), 16'($urandom_range(1, maxd)),
                16'($urandom_range(1, maxd))};
    endfunction

    function automatic logic [17:0] rand_perm(int r);
        int a[6];
        int j, t;
        logic [17:0] p;
        for (int i = 0; i < 6; i++) a[i] = i;
        for (int i = r - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = a[i]; a[i] = a[j]; a[j] = t;
        end
        p = '0;
        for (int i = 0; i < 6; i++) p[3*i +: 3] = a[i];
        return p;
    endfunction

    task automatic test_reset_shape();
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        // 2x3 identity permutation
        set_shape(2, 18'o000010, 48'h0000_0003_0002, 48'h0001_0001_0001);
        for (int i = 0; i < 7; i++) send_index(32'(i));
        // zero-sized dimension: everything out of range
        set_shape(3, 18'o000210, 48'h0004_0000_0002, 48'h0001_0001_0001);
        send_index(32'd0);
        send_index(32'd5);
        // rank 0 acts as 1, rank 7 saturates, axis beyond rank, repeated axis
        set_shape(0, 18'o777777, 48'h0003_0002_0005, 48'h0001_0001_0001);
        send_index(32'd4);
        send_index(32'd5);
        set_shape(7, 18'o012345, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_index(32'hFFFF_FFFF);
        send_index(32'h8000_0001);
        set_shape(3, 18'o000700, 48'h0007_0003_0005, 48'h0001_0001_0001);
        send_index(32'd17);
        send_index(32'd104);
        set_shape(4, 18'o001100, 48'h0003_0004_0002, 48'h0001_0001_0005);
        send_index(32'd37);
        send_index(32'd119);
        send_index(32'd120);
    endtask

    task automatic test_random();
        int r;
        logic [31:0] numel;
        for (int ph = 0; ph < 30; ph++) begin
            r = $urandom_range(0, 7);
            if (ph % 5 == 4)
                set_shape(r, 18'($urandom), 48'({$urandom, $urandom}),
                          48'({$urandom, $urandom}));
            else
                set_shape(r, rand_perm((r < 1) ? 1 : (r > 6 ? 6 : r)),
                          rand_dims(ph % 3 == 0 ? 65535 : 9),
                          rand_dims(ph % 3 == 0 ? 65535 : 9));
            numel = 1;
            for (int i = 0; i < 3; i++) numel = numel * m_dims_lo[16*i +: 16];
            for (int i = 0; i < 3; i++) numel = numel * m_dims_hi[16*i +: 16];
            rand_sink = (ph % 4 != 0);
            for (int k = 0; k < 53; k++)
                if ($urandom_range(0, 9) == 0 || numel == 0) send_index($urandom);
                else send_index(32'($urandom_range(0, numel + numel / 16)),
                                ph % 6 != 1);
        end
    endtask

    // long receiver hold while the sender keeps offering: the pipeline fills
    task automatic test_backpressure();
        set_shape(3, 18'o000102, 48'h0005_0004_0003, 48'h0001_0001_0001);
        hold_cycles = 400;
        for (int k = 0; k < 250; k++) send_index(32'($urandom_range(0, 70)), 1'b0);
        drain();
        send_index(32'd59);
    endtask

    initial begin
        m_rank = RANK_RST;
        m_perm = PERM_RST;
        m_dims_lo = DIMS_RST;
        m_dims_hi = DIMS_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_shape();
        test_directed();
        test_backpressure();
        test_random();
        drain();
        repeat (300) @(posedge i_clk);
        $display("covered %0d transactions, %0d out of range, over 30+ shapes",
                 n_results, n_oor);
        if (n_mismatch == 0 && src_addr_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tti_pkg.sv
sv/tti_cfg.sv
sv/tti_dim.sv
sv/tensor_transpose_index_map.sv
sim/tb.sv
